/* hw/rtl/bsd_pkg.sv */
`timescale 1ns / 1ps

package bsd_pkg;

  // Store geometry
  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  // Request field widths are fixed by the interface
  localparam int FUNC_W  = 3;
  localparam int POS_W   = 4;
  localparam int VALUE_W = 32;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;

  // Width that holds both a position and a count for compares
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [FUNC_W-1:0] {
    FN_READ       = 3'd0,
    FN_PUSH_FRONT = 3'd1,
    FN_PUSH_BACK  = 3'd2,
    FN_POP_FRONT  = 3'd3,
    FN_POP_BACK   = 3'd4,
    FN_INSERT     = 3'd5
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [POS_W-1:0]   pos;
    logic [VALUE_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [VALUE_W-1:0] read_value;
    logic [STAT_W-1:0]  status;
    logic [COUNT_W-1:0] count;
  } out_t;

  // Per-cell move command
  typedef struct packed {
    logic load;        // take the request value
    logic take_left;   // take the lower neighbor (shift toward the back)
    logic take_right;  // take the upper neighbor (shift toward the front)
  } cell_ctl_t;

endpackage

/* hw/rtl/bsd_cell.sv */
`timescale 1ns / 1ps

module bsd_cell (
  input  logic                           clk,
  input  bsd_pkg::cell_ctl_t             ctl,
  input  logic [bsd_pkg::DATA_WIDTH-1:0] din,
  input  logic [bsd_pkg::DATA_WIDTH-1:0] left_q,
  input  logic [bsd_pkg::DATA_WIDTH-1:0] right_q,
  output logic [bsd_pkg::DATA_WIDTH-1:0] q
);

  logic [bsd_pkg::DATA_WIDTH-1:0] data_r;
  logic [bsd_pkg::DATA_WIDTH-1:0] data_nxt;

  // Pick the new content: load, shift from a neighbor, or hold
  always_comb begin
    data_nxt = data_r;
    if (ctl.load) begin
      data_nxt = din;
    end else if (ctl.take_left) begin
      data_nxt = left_q;
    end else if (ctl.take_right) begin
      data_nxt = right_q;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q = data_r;

endmodule

/* hw/rtl/bounded_sequence_deque_top.sv */
`timescale 1ns / 1ps

// Bounded ordered store of up to bsd_pkg::CAPACITY elements, position 0 at the
// front, kept in a row of element cells that shift in the same clock edge. For each
// request (read at position, push front/back, pop front/back, insert after
// position) every cell moves to its neighbor, loads the new value or holds in
// the same clock edge, and a registered result (value, status, count after the
// operation) appears on the out_ channel the cycle after the request is accepted.
// A new request is taken in every cycle in which the result register is empty or
// being drained, so sustained rate is one request per cycle. No clearing pass
// follows reset; only the count and the result valid flag are cleared.
module bounded_sequence_deque_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  bsd_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output bsd_pkg::out_t out_data
);

  localparam int CAP = bsd_pkg::CAPACITY;
  localparam int DW  = bsd_pkg::DATA_WIDTH;

  logic [bsd_pkg::CNT_W-1:0] count_r;
  logic [bsd_pkg::CNT_W-1:0] count_nxt;
  logic                      out_valid_r;
  bsd_pkg::out_t             out_data_r;
  bsd_pkg::out_t             out_data_nxt;

  logic [DW-1:0]      cell_q   [CAP];
  bsd_pkg::cell_ctl_t cell_ctl [CAP];
  logic [DW-1:0]      new_val;

  logic                      fire;
  logic                      is_full;
  logic                      is_empty;
  logic                      pos_bad;
  logic [bsd_pkg::CMP_W-1:0] pos_ext;
  logic [bsd_pkg::CMP_W-1:0] cnt_ext;
  logic [bsd_pkg::CMP_W-1:0] ins_at;
  logic [bsd_pkg::CMP_W-1:0] rd_sel;
  logic [bsd_pkg::IDX_W-1:0] rd_idx;
  logic [DW-1:0]             rd_data;
  logic                      do_pf;
  logic                      do_pb;
  logic                      do_popf;
  logic                      do_ins;

  // Accept while the result register is free or draining
  assign in_ready = !out_valid_r || out_ready;
  assign fire     = in_valid && in_ready;

  assign is_full  = (count_r == bsd_pkg::CNT_W'(CAP));
  assign is_empty = (count_r == '0);
  assign pos_ext  = bsd_pkg::CMP_W'(in_data.pos);
  assign cnt_ext  = bsd_pkg::CMP_W'(count_r);
  assign pos_bad  = (pos_ext >= cnt_ext);
  assign ins_at   = pos_ext + bsd_pkg::CMP_W'(1);
  assign new_val  = DW'(in_data.value);

  // Single read port: position for read, front for pop front, last for pop back
  always_comb begin
    rd_sel = '0;
    case (in_data.func)
      bsd_pkg::FN_READ:     rd_sel = pos_ext;
      bsd_pkg::FN_POP_BACK: rd_sel = cnt_ext - bsd_pkg::CMP_W'(1);
      default:              rd_sel = '0;
    endcase
  end
  assign rd_idx  = rd_sel[bsd_pkg::IDX_W-1:0];
  assign rd_data = cell_q[rd_idx];

  // Decode the request into status, result and the kind of move
  always_comb begin
    out_data_nxt = '0;
    count_nxt    = count_r;
    do_pf        = 1'b0;
    do_pb        = 1'b0;
    do_popf      = 1'b0;
    do_ins       = 1'b0;
    case (in_data.func)
      bsd_pkg::FN_READ: begin
        if (pos_bad) begin
          out_data_nxt.status = bsd_pkg::ST_BADPOS;
        end else begin
          out_data_nxt.read_value = bsd_pkg::VALUE_W'(rd_data);
        end
      end
      bsd_pkg::FN_PUSH_FRONT: begin
        if (is_full) begin
          out_data_nxt.status = bsd_pkg::ST_FULL;
        end else begin
          do_pf     = 1'b1;
          count_nxt = count_r + bsd_pkg::CNT_W'(1);
        end
      end
      bsd_pkg::FN_PUSH_BACK: begin
        if (is_full) begin
          out_data_nxt.status = bsd_pkg::ST_FULL;
        end else begin
          do_pb     = 1'b1;
          count_nxt = count_r + bsd_pkg::CNT_W'(1);
        end
      end
      bsd_pkg::FN_POP_FRONT: begin
        if (is_empty) begin
          out_data_nxt.status = bsd_pkg::ST_EMPTY;
        end else begin
          out_data_nxt.read_value = bsd_pkg::VALUE_W'(rd_data);
          do_popf   = 1'b1;
          count_nxt = count_r - bsd_pkg::CNT_W'(1);
        end
      end
      bsd_pkg::FN_POP_BACK: begin
        if (is_empty) begin
          out_data_nxt.status = bsd_pkg::ST_EMPTY;
        end else begin
          out_data_nxt.read_value = bsd_pkg::VALUE_W'(rd_data);
          count_nxt = count_r - bsd_pkg::CNT_W'(1);
        end
      end
      bsd_pkg::FN_INSERT: begin
        if (pos_bad) begin
          out_data_nxt.status = bsd_pkg::ST_BADPOS;
        end else if (is_full) begin
          out_data_nxt.status = bsd_pkg::ST_FULL;
        end else begin
          do_ins    = 1'b1;
          count_nxt = count_r + bsd_pkg::CNT_W'(1);
        end
      end
      default: begin
        out_data_nxt = '0;
      end
    endcase
    out_data_nxt.count = bsd_pkg::COUNT_W'(count_nxt);
  end

  // Drive each cell: load at the target slot, shift the cells that move
  always_comb begin
    for (int i = 0; i < CAP; i++) begin
      cell_ctl[i].load = fire && (
          (do_pf  && (i == 0)) ||
          (do_pb  && (bsd_pkg::CMP_W'(i) == cnt_ext)) ||
          (do_ins && (bsd_pkg::CMP_W'(i) == ins_at)));
      cell_ctl[i].take_left = fire && (
          (do_pf  && (i != 0)) ||
          (do_ins && (bsd_pkg::CMP_W'(i) > ins_at)));
      cell_ctl[i].take_right = fire && do_popf;
    end
  end

  // Row of element cells
  for (genvar g = 0; g < CAP; g++) begin : g_cell
    logic [DW-1:0] left_q;
    logic [DW-1:0] right_q;

    if (g == 0) begin : g_first
      assign left_q = '0;
    end else begin : g_mid_l
      assign left_q = cell_q[g-1];
    end

    if (g == CAP - 1) begin : g_last
      assign right_q = '0;
    end else begin : g_mid_r
      assign right_q = cell_q[g+1];
    end

    bsd_cell u_cell (
      .clk     (clk),
      .ctl     (cell_ctl[g]),
      .din     (new_val),
      .left_q  (left_q),
      .right_q (right_q),
      .q       (cell_q[g])
    );
  end

  // Hold count and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= bsd_pkg::CNT_W'(CAP))
    else $error("element count above capacity");

  a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> (out_valid_r && (out_data_r.count == bsd_pkg::COUNT_W'(count_r))))
    else $error("result missing or count mismatch after request");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.status == bsd_pkg::ST_FULL)) |->
      (count_r == bsd_pkg::CNT_W'(CAP)))
    else $error("full status with room left");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.status == bsd_pkg::ST_EMPTY)) |->
      (count_r == '0))
    else $error("empty status with elements stored");

  a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(count_r))
    else $error("count moved without a request");
`endif

endmodule
